// ===== rtl/pfde_pkg.sv =====
// shared types and constants for the page framebuffer draw engine
// no dependencies; every other rtl file refers to it by scoped names
package pfde_pkg;

  // default screen size in pixels
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  // frame store: 8 pages of 128 columns, one byte each
  localparam int PAGE_W      = 3;
  localparam int COL_W       = 7;
  localparam int ADDR_W      = PAGE_W + COL_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // job queue between command decode and execution
  localparam int JOB_QDEPTH = 4;
  localparam int JOB_QPTR_W = $clog2(JOB_QDEPTH);

  // command codes as they arrive on the input tuser
  typedef enum logic [2:0] {
    OP_PIXEL   = 3'd0,
    OP_HLINE   = 3'd1,
    OP_RECT    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_FILL    = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // work kinds carried by the job queue
  typedef enum logic [1:0] {
    JOB_NOP  = 2'd0,
    JOB_RECT = 2'd1,
    JOB_FILL = 2'd2,
    JOB_READ = 2'd3
  } job_kind_t;

  // one unit of work; last marks the job that closes a command
  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic              on;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic              last;
  } job_t;

  // execution states
  typedef enum logic [2:0] {
    B_IDLE,
    B_WRITE,
    B_RDATA,
    B_SWEEP,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/pfde_front.sv =====
// command decode: takes one command request and splits it into jobs
// depends on pfde_pkg
module pfde_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      init_done,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  pfde_pkg::op_t             cmd_op,
  input  logic [7:0]                cmd_x,
  input  logic [7:0]                cmd_y,
  input  logic [7:0]                cmd_w,
  input  logic [7:0]                cmd_h,
  input  logic                      cmd_on,
  input  logic [pfde_pkg::PAGE_W-1:0] cmd_page,
  input  logic [pfde_pkg::COL_W-1:0]  cmd_col,
  output logic                      job_push,
  output pfde_pkg::job_t            job,
  input  logic                      job_full
);

  pfde_pkg::op_t              op_r;
  logic [7:0]                 x_r, y_r, w_r, h_r;
  logic                       on_r;
  logic [pfde_pkg::PAGE_W-1:0] page_r;
  logic [pfde_pkg::COL_W-1:0]  col_r;
  logic                       held_r;
  logic [1:0]                 seq_r;
  logic                       take;

  // job generation from the held command and segment counter
  always_comb begin
    job       = '0;
    job.kind  = pfde_pkg::JOB_NOP;
    job.x     = x_r;
    job.y     = y_r;
    job.w     = w_r;
    job.h     = h_r;
    job.on    = on_r;
    job.page  = page_r;
    job.col   = col_r;
    job.last  = 1'b1;
    case (op_r)
      pfde_pkg::OP_PIXEL: begin
        job.kind = pfde_pkg::JOB_RECT;
        job.w    = 8'd1;
        job.h    = 8'd1;
      end
      pfde_pkg::OP_HLINE: begin
        job.kind = pfde_pkg::JOB_RECT;
        job.h    = 8'd1;
      end
      pfde_pkg::OP_RECT: begin
        job.kind = pfde_pkg::JOB_RECT;
      end
      pfde_pkg::OP_OUTLINE: begin
        // outline is four one-pixel-thick rectangles
        if (w_r != 8'd0 && h_r != 8'd0) begin
          job.kind = pfde_pkg::JOB_RECT;
          case (seq_r)
            2'd0: begin
              job.h    = 8'd1;
              job.last = 1'b0;
            end
            2'd1: begin
              job.y    = y_r + h_r - 8'd1;
              job.h    = 8'd1;
              job.last = 1'b0;
            end
            2'd2: begin
              job.w    = 8'd1;
              job.last = 1'b0;
            end
            default: begin
              job.x = x_r + w_r - 8'd1;
              job.w = 8'd1;
            end
          endcase
        end
      end
      pfde_pkg::OP_FILL: begin
        job.kind = pfde_pkg::JOB_FILL;
      end
      pfde_pkg::OP_READ: begin
        job.kind = pfde_pkg::JOB_READ;
      end
      default: begin
        job.kind = pfde_pkg::JOB_NOP;
      end
    endcase
  end

  // handshake: a new command enters once the held one has sent its last job
  assign job_push  = held_r && !job_full;
  assign cmd_ready = init_done && (!held_r || (job_push && job.last));
  assign take      = cmd_valid && cmd_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      seq_r  <= 2'd0;
    end else if (take) begin
      held_r <= 1'b1;
      seq_r  <= 2'd0;
    end else if (job_push) begin
      if (job.last) begin
        held_r <= 1'b0;
      end
      seq_r <= seq_r + 2'd1;
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= cmd_op;
      x_r    <= cmd_x;
      y_r    <= cmd_y;
      w_r    <= cmd_w;
      h_r    <= cmd_h;
      on_r   <= cmd_on;
      page_r <= cmd_page;
      col_r  <= cmd_col;
    end
  end

endmodule

// ===== rtl/pfde_job_q.sv =====
// short job queue between decode and execution
// depends on pfde_pkg
module pfde_job_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pfde_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output pfde_pkg::job_t head,
  output logic           valid
);

  pfde_pkg::job_t                    slot_r [pfde_pkg::JOB_QDEPTH];
  logic [pfde_pkg::JOB_QPTR_W-1:0]   wptr_r, rptr_r;
  logic [pfde_pkg::JOB_QPTR_W:0]     cnt_r;

  assign full  = (cnt_r == (pfde_pkg::JOB_QPTR_W+1)'(pfde_pkg::JOB_QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/pfde_back.sv =====
// execution: frame store, pixel read-modify-write walker, fill sweep, reads
// depends on pfde_pkg
module pfde_back #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pfde_pkg::job_t q_job,
  input  logic           q_valid,
  output logic           q_pop,
  output logic           init_done,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [7:0]     res_data
);

  localparam int SCREEN_PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int AW           = pfde_pkg::ADDR_W;

  logic [7:0]   mem [pfde_pkg::STORE_DEPTH];
  logic [7:0]   rdata_r;

  pfde_pkg::back_state_t state_r, state_nxt;
  logic [7:0]   i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]   bit_r, bit_nxt;
  logic [7:0]   res_r, res_nxt;
  logic [AW-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [7:0]   sweep_val_r, sweep_val_nxt;
  logic         sweep_res_r, sweep_res_nxt;
  logic         init_done_r, init_done_nxt;

  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]   mem_wdata;

  logic [7:0]   px, py;
  logic         px_on, rd_vis, is_empty, row_end, last_px;
  logic         do_adv, do_fin;
  logic [7:0]   bit_mask;

  // pixel position and screen checks
  assign px       = q_job.x + j_r;
  assign py       = q_job.y + i_r;
  assign px_on    = (px < 8'(SCREEN_WIDTH)) && (py < 8'(SCREEN_HEIGHT));
  assign rd_vis   = ({1'b0, q_job.col} < 8'(SCREEN_WIDTH))
                 && ({1'b0, q_job.page} < 4'(SCREEN_PAGES));
  assign is_empty = (q_job.w == 8'd0) || (q_job.h == 8'd0);
  assign row_end  = (j_r == q_job.w - 8'd1);
  assign last_px  = row_end && (i_r == q_job.h - 8'd1);
  assign bit_mask = 8'd1 << bit_r;

  assign init_done = init_done_r;
  assign res_data  = res_r;

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    addr_nxt      = addr_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    sweep_cnt_nxt = sweep_cnt_r;
    sweep_val_nxt = sweep_val_r;
    sweep_res_nxt = sweep_res_r;
    init_done_nxt = init_done_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = 8'd0;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    q_pop         = 1'b0;
    res_valid     = 1'b0;
    do_adv        = 1'b0;
    do_fin        = 1'b0;
    case (state_r)
      pfde_pkg::B_SWEEP: begin
        // one byte a cycle, reset clear or fill all
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt_r;
        mem_wdata = sweep_val_r;
        if (sweep_cnt_r == AW'(pfde_pkg::STORE_DEPTH - 1)) begin
          sweep_cnt_nxt = '0;
          if (sweep_res_r) begin
            do_fin = 1'b1;
          end else begin
            init_done_nxt = 1'b1;
            state_nxt     = pfde_pkg::B_IDLE;
          end
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end
      end
      pfde_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_job.kind)
            pfde_pkg::JOB_RECT: begin
              res_nxt = 8'd0;
              if (is_empty) begin
                do_fin = 1'b1;
              end else if (px_on) begin
                mem_re    = 1'b1;
                mem_raddr = {py[5:3], px[6:0]};
                addr_nxt  = {py[5:3], px[6:0]};
                bit_nxt   = py[2:0];
                state_nxt = pfde_pkg::B_WRITE;
              end else begin
                do_adv = 1'b1;
              end
            end
            pfde_pkg::JOB_FILL: begin
              res_nxt       = 8'd0;
              sweep_val_nxt = {8{q_job.on}};
              sweep_res_nxt = 1'b1;
              sweep_cnt_nxt = '0;
              state_nxt     = pfde_pkg::B_SWEEP;
            end
            pfde_pkg::JOB_READ: begin
              if (rd_vis) begin
                mem_re    = 1'b1;
                mem_raddr = {q_job.page, q_job.col};
                state_nxt = pfde_pkg::B_RDATA;
              end else begin
                res_nxt = 8'd0;
                do_fin  = 1'b1;
              end
            end
            default: begin
              res_nxt = 8'd0;
              do_fin  = 1'b1;
            end
          endcase
        end
      end
      pfde_pkg::B_WRITE: begin
        // modify the byte fetched last cycle
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = q_job.on ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
        state_nxt = pfde_pkg::B_IDLE;
        do_adv    = 1'b1;
      end
      pfde_pkg::B_RDATA: begin
        res_nxt = rdata_r;
        do_fin  = 1'b1;
      end
      pfde_pkg::B_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          q_pop     = 1'b1;
          state_nxt = pfde_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = pfde_pkg::B_IDLE;
      end
    endcase

    // step to the next pixel, row by row
    if (do_adv) begin
      if (last_px) begin
        do_fin = 1'b1;
      end else if (row_end) begin
        j_nxt = 8'd0;
        i_nxt = i_r + 8'd1;
      end else begin
        j_nxt = j_r + 8'd1;
      end
    end

    // job complete: report if it closes a command, else drop it
    if (do_fin) begin
      i_nxt = 8'd0;
      j_nxt = 8'd0;
      if (q_job.last) begin
        state_nxt = pfde_pkg::B_DONE;
      end else begin
        q_pop     = 1'b1;
        state_nxt = pfde_pkg::B_IDLE;
      end
    end
  end

  // control registers; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfde_pkg::B_SWEEP;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      sweep_cnt_r <= '0;
      sweep_val_r <= 8'd0;
      sweep_res_r <= 1'b0;
      init_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sweep_val_r <= sweep_val_nxt;
      sweep_res_r <= sweep_res_nxt;
      init_done_r <= init_done_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    bit_r  <= bit_nxt;
    res_r  <= res_nxt;
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/page_framebuffer_draw_engine_core.sv =====
// top level of the page framebuffer draw engine with the output stage
// depends on pfde_pkg, pfde_front, pfde_job_q and pfde_back
//
// usage: each request on the in_ channel is one drawing command (pixel,
// horizontal line, filled rectangle, rectangle outline, fill all, read
// byte), selected by in_tuser. every command yields exactly one request on
// the out_ channel: the byte read for a read command, zero otherwise.
// the frame store holds pages of 8 vertical pixels, one byte per column.
// after reset a clearing sweep writes all 1024 bytes to zero, one a cycle;
// in_tready stays low until the sweep is done.
// a decode stage splits commands into jobs (an outline into four sides)
// and feeds a four-entry queue; the execution unit drains it. execution
// is bound by the frame store: an on-screen pixel is read, then written
// back, an off-screen one is skipped, fill all sweeps every byte and then
// reports, and a read fetches its byte and then reports. decode can take
// a new command while earlier ones are still executing.
// a registered output stage holds a finished result while decode keeps
// taking commands; when out_tready stays low the queue fills and then
// in_tready drops, with nothing lost.
module page_framebuffer_draw_engine_core #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x[7:0], y[15:8], width[23:16], height[31:24], pixel_on[32],
  // read_page[35:33], read_column[42:36], zero fill [47:43]
  input  logic [47:0] in_tdata,
  // operation[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata
);

  logic           init_done;
  logic           job_push, job_full, q_pop, q_valid;
  pfde_pkg::job_t job_in, q_head;
  logic           res_valid, res_ready;
  logic [7:0]     res_data;
  logic           out_valid_r;
  logic [7:0]     out_data_r;

  pfde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .cmd_valid (in_tvalid),
    .cmd_ready (in_tready),
    .cmd_op    (pfde_pkg::op_t'(in_tuser)),
    .cmd_x     (in_tdata[7:0]),
    .cmd_y     (in_tdata[15:8]),
    .cmd_w     (in_tdata[23:16]),
    .cmd_h     (in_tdata[31:24]),
    .cmd_on    (in_tdata[32]),
    .cmd_page  (in_tdata[35:33]),
    .cmd_col   (in_tdata[42:36]),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  pfde_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid)
  );

  pfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .init_done (init_done),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // output register, refilled as soon as it drains
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule

// ===== dv/tb_page_framebuffer_draw_engine_core.sv =====
// testbench for page_framebuffer_draw_engine_core: drawing commands with expected read bytes
// depends on pfde_pkg and the rtl of the draw engine; a local copy of the frame store predicts
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_engine_core;
  import pfde_pkg::*;

  localparam int SCR_W    = SCREEN_WIDTH_DEF;
  localparam int SCR_H    = SCREEN_HEIGHT_DEF;
  localparam int PAGE_CNT = (SCR_H + 7) / 8;
  // the stall limit allows for a 255x255 rectangle, the longest command
  localparam int STALL_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // codes outside the command set; they draw nothing
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       on;
    logic [2:0] page;
    logic [6:0] col;
    bit         fixed;
    logic [7:0] fixed_val;
  } draw_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  logic [7:0]  frame_bytes [STORE_DEPTH];
  logic [7:0]  read_byte_q [$];
  draw_cmd_t   directed_rows [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_req;
  int          fail_count;
  int          stall_count;

  page_framebuffer_draw_engine_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void plot_pixel(logic [7:0] px, logic [7:0] py, logic on);
    int unsigned idx;
    if (px >= SCR_W || py >= SCR_H) return;
    idx = (py >> 3) * SCR_W + px;
    if (idx >= STORE_DEPTH) return;
    frame_bytes[idx][py[2:0]] = on;
  endfunction

  function automatic void paint_rect(logic [7:0] x, logic [7:0] y, int w, int h, logic on);
    for (int i = 0; i < h; i++)
      for (int j = 0; j < w; j++)
        plot_pixel(8'(x + j), 8'(y + i), on);
  endfunction

  function automatic void paint_outline(logic [7:0] x, logic [7:0] y, int w, int h, logic on);
    if (w == 0 || h == 0) return;
    for (int j = 0; j < w; j++) begin
      plot_pixel(8'(x + j), y, on);
      plot_pixel(8'(x + j), 8'(y + h - 1), on);
    end
    for (int i = 0; i < h; i++) begin
      plot_pixel(x, 8'(y + i), on);
      plot_pixel(8'(x + w - 1), 8'(y + i), on);
    end
  endfunction

  // applies one command to the local frame store, returns the byte the block sends back
  function automatic logic [7:0] draw_and_read(draw_cmd_t c);
    logic [7:0] data;
    data = 8'h00;
    case (c.op)
      OP_PIXEL:   plot_pixel(c.x, c.y, c.on);
      OP_HLINE:   paint_rect(c.x, c.y, int'(c.w), 1, c.on);
      OP_RECT:    paint_rect(c.x, c.y, int'(c.w), int'(c.h), c.on);
      OP_OUTLINE: paint_outline(c.x, c.y, int'(c.w), int'(c.h), c.on);
      OP_FILL: begin
        foreach (frame_bytes[i]) frame_bytes[i] = c.on ? 8'hFF : 8'h00;
      end
      OP_READ: begin
        if (c.col < SCR_W && c.page < PAGE_CNT)
          data = frame_bytes[c.page * SCR_W + c.col];
      end
      default: ;
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic draw_cmd_t mk_cmd(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                       logic [7:0] w, logic [7:0] h, logic on,
                                       logic [2:0] page, logic [6:0] col,
                                       bit fixed = 1'b0, logic [7:0] fixed_val = 8'h00);
    draw_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.w = w;
    c.h = h;
    c.on = on;
    c.page = page;
    c.col = col;
    c.fixed = fixed;
    c.fixed_val = fixed_val;
    return c;
  endfunction

  // mostly on-screen shapes of small size, so reads see drawn pixels
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    c.x = ($urandom_range(99) < 80) ? 8'($urandom_range(SCR_W - 1)) : 8'($urandom_range(255));
    c.y = ($urandom_range(99) < 80) ? 8'($urandom_range(SCR_H - 1)) : 8'($urandom_range(255));
    c.w = 8'($urandom);
    c.h = 8'($urandom);
    c.on = 1'($urandom);
    c.page = 3'($urandom);
    c.col = 7'($urandom);
    c.fixed = 1'b0;
    c.fixed_val = 8'h00;
    if (pick < 25) begin
      c.op = OP_PIXEL;
    end else if (pick < 40) begin
      c.op = OP_HLINE;
      if (sub < 70) c.w = 8'($urandom_range(31));
    end else if (pick < 55) begin
      c.op = OP_RECT;
      if (sub < 85) begin
        c.w = 8'($urandom_range(12));
        c.h = 8'($urandom_range(12));
      end else if (sub < 93) begin
        c.h = 8'($urandom_range(6));
      end else begin
        c.w = 8'($urandom_range(6));
      end
    end else if (pick < 67) begin
      c.op = OP_OUTLINE;
      if (sub < 70) begin
        c.w = 8'($urandom_range(20));
        c.h = 8'($urandom_range(20));
      end
    end else if (pick < 70) begin
      c.op = OP_FILL;
    end else if (pick < 97) begin
      c.op = OP_READ;
    end else begin
      c.op = (sub < 50) ? OP_SPARE6 : OP_SPARE7;
    end
    return c;
  endfunction

  // offers one request, predicts at the edge it is taken
  task automatic send_cmd(input draw_cmd_t c);
    logic [7:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {5'b0, c.col, c.page, c.on, c.h, c.w, c.y, c.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = draw_and_read(c);
    read_byte_q.push_back(c.fixed ? c.fixed_val : want);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (read_byte_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (read_byte_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result %02h at %0t", out_tdata, $realtime);
      end else begin
        want = read_byte_q.pop_front();
        if (out_tdata !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("read_data mismatch: expected %02h got %02h at %0t",
                     want, out_tdata, $realtime);
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    hold_off_req = 1'b0;
    fail_count = 0;
    stall_count = 0;
    send_idle_pct = 33;
    recv_idle_pct = 50;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;

    // directed rows: op, x, y, w, h, on, page, col, fixed, value
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 0,   0, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_READ,  255, 255, 255, 255,   1, 7, 127, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_PIXEL,   0,   0,   0,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_PIXEL, 127,  63, 255, 255,   1, 7, 127));
    // off-screen pixels are dropped
    directed_rows.push_back(mk_cmd(OP_PIXEL, 128,   0,   0,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_PIXEL, 255, 255,   0,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 0,   0, 1, 8'h01));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 7, 127, 1, 8'h80));
    // line wrapping past column 255 back to zero
    directed_rows.push_back(mk_cmd(OP_HLINE, 250,  10,  20,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_HLINE,  30,  20,   0,   9,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_HLINE,   0,  63, 255,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 1,   3));
    directed_rows.push_back(mk_cmd(OP_RECT,  120,  60,  16,   8,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 7, 124));
    // largest rectangle wraps over the whole screen and clears it
    directed_rows.push_back(mk_cmd(OP_RECT,  255, 255, 255, 255,   0, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 3,  64, 1, 8'h00));
    // outlines with an empty side draw nothing
    directed_rows.push_back(mk_cmd(OP_OUTLINE, 10,  5,   0,   7,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_OUTLINE, 10,  5,   7,   0,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_OUTLINE,  2,  3,  20,  12,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_OUTLINE, 250, 250, 255, 255, 1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_OUTLINE, 40, 40,   1,   1,   1, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 0,   2));
    directed_rows.push_back(mk_cmd(OP_FILL,    0,   0,   0,   0,   1, 0,   0, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 7, 127, 1, 8'hFF));
    directed_rows.push_back(mk_cmd(OP_SPARE6, 5,    9,   3,   3,   0, 1,   5, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_SPARE7, 5,    9,   3,   3,   0, 1,   5, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_PIXEL,   5,   9,   0,   0,   0, 0,   0));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 1,   5));
    directed_rows.push_back(mk_cmd(OP_FILL,  255, 255, 255, 255,   0, 7, 127, 1, 8'h00));
    directed_rows.push_back(mk_cmd(OP_READ,    0,   0,   0,   0,   0, 5, 100, 1, 8'h00));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_cmd(directed_rows[i]);

    // receiver idles more than the sender
    for (int n = 0; n < 400; n++) send_cmd(random_cmd());
    in_tvalid <= 1'b0;
    wait_drained();

    // sender idles more than the receiver
    send_idle_pct = 50;
    recv_idle_pct = 33;
    for (int n = 0; n < 400; n++) send_cmd(random_cmd());
    in_tvalid <= 1'b0;
    wait_drained();

    // no idling; a long receiver hold-off backs the engine up first
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    for (int n = 0; n < 400; n++) send_cmd(random_cmd());
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
